@@ src/imuavg_pkg.sv @@
package imuavg_pkg;

	// fixed field widths
	localparam int SAMPLE_W    = 16;
	localparam int COEF_FRAC   = 12;
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_INDEX_W = 3;

	// default averaging window
	localparam int WINDOW_DEF = 8;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t x;
		sample_t y;
		sample_t z;
	} vec3_t;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAG_ENABLE  = 3'd0,
		REG_OFFSET_X    = 3'd1,
		REG_OFFSET_Y    = 3'd2,
		REG_OFFSET_Z    = 3'd3,
		REG_MATRIX_ROW0 = 3'd4,
		REG_MATRIX_ROW1 = 3'd5,
		REG_MATRIX_ROW2 = 3'd6
	} cfg_reg_t;

	// identity soft iron matrix, 1.0 in q3.12
	localparam logic [CFG_DATA_W-1:0] ROW0_RESET = 48'h0000_0000_1000;
	localparam logic [CFG_DATA_W-1:0] ROW1_RESET = 48'h0000_1000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW2_RESET = 48'h1000_0000_0000;

	// pipeline control shared by the datapath modules
	typedef struct packed {
		logic adv;   // whole pipeline moves this cycle
		logic take;  // input transaction accepted this cycle
		logic v1;    // stage 1 holds a transaction
		logic v2;    // stage 2 holds a transaction
	} pipe_ctl_t;

endpackage

@@ src/imuavg_cell.sv @@
module imuavg_cell import imuavg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  vec3_t din,
	output vec3_t dout
);

	vec3_t data_q;

	// one window slot, handed to the next cell on every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;

endmodule

@@ src/imuavg_mean.sv @@
module imuavg_mean import imuavg_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  vec3_t     accel,
	output vec3_t     avg
);

	localparam int CW      = $clog2(WINDOW);
	localparam int SUM_W   = SAMPLE_W + CW;
	localparam int SHIFT_K = SUM_W + CW;
	localparam int MUL_W   = SUM_W + 1;
	localparam int PROD_W  = SUM_W + MUL_W;
	// reciprocal of the window, exact floor division for any biased sum
	localparam logic [MUL_W-1:0] RECIP =
		MUL_W'(((64'd1 << SHIFT_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	// bias that keeps the running sum non-negative
	localparam logic [SUM_W-1:0] BIAS = SUM_W'(64'(WINDOW) << (SAMPLE_W - 1));

	vec3_t             tap [WINDOW+1];
	sample_t           a_new [3];
	sample_t           a_old [3];
	logic [SUM_W-1:0]  usum_q [3];
	logic [PROD_W-1:0] prod_s2 [3];
	logic [SAMPLE_W-1:0] q_s3 [3];
	sample_t           avg_s3 [3];

	// chain of window cells, newest sample enters cell 0
	assign tap[0] = accel;
	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		imuavg_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (ctl.take),
			.din   (tap[k]),
			.dout  (tap[k+1])
		);
	end

	assign a_new = '{accel.x, accel.y, accel.z};
	assign a_old = '{tap[WINDOW].x, tap[WINDOW].y, tap[WINDOW].z};

	// biased running sums: add newest, drop the sample leaving the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) usum_q[i] <= BIAS;
		end else if (ctl.take) begin
			for (int i = 0; i < 3; i++) begin
				usum_q[i] <= usum_q[i] + SUM_W'(a_new[i]) - SUM_W'(a_old[i]);
			end
		end
	end

	// divide by the window through the reciprocal
	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.v1) begin
			for (int i = 0; i < 3; i++) prod_s2[i] <= PROD_W'(usum_q[i]) * PROD_W'(RECIP);
		end
	end

	// take the quotient and remove the bias by flipping the sign bit
	always_comb begin
		for (int i = 0; i < 3; i++) q_s3[i] = prod_s2[i][SHIFT_K +: SAMPLE_W];
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.v2) begin
			for (int i = 0; i < 3; i++) begin
				avg_s3[i] <= {~q_s3[i][SAMPLE_W-1], q_s3[i][SAMPLE_W-2:0]};
			end
		end
	end

	assign avg = '{x: avg_s3[0], y: avg_s3[1], z: avg_s3[2]};

	// running sums only move with an accepted sample
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.take |=> $stable(usum_q[0]) && $stable(usum_q[1]) && $stable(usum_q[2]))
		else $error("running sum changed without a transaction");

endmodule

@@ src/imuavg_mag.sv @@
module imuavg_mag import imuavg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pipe_ctl_t              ctl,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  vec3_t                  raw,
	output vec3_t                  field,
	output logic                   fresh
);

	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = SAMPLE_W + DIFF_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(2 ** (SAMPLE_W - 1));

	logic                     mag_en_q;
	sample_t                  offset_q [3];
	logic [CFG_DATA_W-1:0]    row_q [3];
	sample_t                  raw_a [3];
	logic signed [DIFF_W-1:0] d_s1 [3];
	logic                     fresh_s1;
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic                     fresh_s2;
	logic signed [ACC_W-1:0]  acc [3];
	logic signed [ACC_W-1:0]  sh [3];
	sample_t                  sat [3];
	vec3_t                    held_q;
	logic                     fresh_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_en_q <= 1'b1;
			for (int i = 0; i < 3; i++) offset_q[i] <= '0;
			row_q[0] <= ROW0_RESET;
			row_q[1] <= ROW1_RESET;
			row_q[2] <= ROW2_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAG_ENABLE:  mag_en_q    <= cfg_data[0];
				REG_OFFSET_X:    offset_q[0] <= cfg_data[SAMPLE_W-1:0];
				REG_OFFSET_Y:    offset_q[1] <= cfg_data[SAMPLE_W-1:0];
				REG_OFFSET_Z:    offset_q[2] <= cfg_data[SAMPLE_W-1:0];
				REG_MATRIX_ROW0: row_q[0]    <= cfg_data;
				REG_MATRIX_ROW1: row_q[1]    <= cfg_data;
				REG_MATRIX_ROW2: row_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign raw_a = '{raw.x, raw.y, raw.z};

	// hard iron offset removal, all-zero vector means no reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_s1 <= 1'b0;
		end else if (ctl.take) begin
			fresh_s1 <= mag_en_q && (raw != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			for (int i = 0; i < 3; i++) d_s1[i] <= DIFF_W'(raw_a[i]) - DIFF_W'(offset_q[i]);
		end
	end

	// soft iron products, one per matrix coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_s2 <= 1'b0;
		end else if (ctl.adv && ctl.v1) begin
			fresh_s2 <= fresh_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.v1) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= PROD_W'($signed(row_q[r][SAMPLE_W*c +: SAMPLE_W]))
						* PROD_W'(d_s1[c]);
				end
			end
		end
	end

	// row sums, floor shift by the coefficient fraction, saturate
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = ACC_W'(prod_s2[r][0]) + ACC_W'(prod_s2[r][1]) + ACC_W'(prod_s2[r][2]);
			sh[r]  = acc[r] >>> COEF_FRAC;
			if (sh[r] > SAT_MAX) begin
				sat[r] = SAT_MAX[SAMPLE_W-1:0];
			end else if (sh[r] < SAT_MIN) begin
				sat[r] = SAT_MIN[SAMPLE_W-1:0];
			end else begin
				sat[r] = sh[r][SAMPLE_W-1:0];
			end
		end
	end

	// held field, replaced only by a fresh reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			fresh_q <= 1'b0;
		end else if (ctl.adv && ctl.v2) begin
			fresh_q <= fresh_s2;
			if (fresh_s2) begin
				held_q <= '{x: sat[0], y: sat[1], z: sat[2]};
			end
		end
	end

	assign field = held_q;
	assign fresh = fresh_q;

	// a stale transaction must not touch the held field
	a_held_keep: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv && ctl.v2 && !fresh_s2 |=> $stable(held_q))
		else $error("held field changed on a stale transaction");

	// disabled magnetometer never produces a fresh reading
	a_disable: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take && !mag_en_q && !cfg_we |=> !fresh_s1)
		else $error("fresh reading while magnetometer disabled");

endmodule

@@ src/imu_average_and_mag_iron_correct_unit.sv @@
// imu sample averager with magnetometer hard and soft iron correction
//
// input channel (in_valid/in_ready) carries one sensor sample: three
// accelerometer axes and three raw magnetometer axes. output channel
// (out_valid/out_ready) returns one result per sample: the floor mean of the
// last WINDOW accelerometer samples per axis, the corrected field and a
// field_fresh flag. the window is a chain of WINDOW cells that shift on each
// accepted transaction, with a running sum per axis.
// pipeline: a sample passes three registered stages once accepted (offset
// and running sum, reciprocal multiply and matrix products, output register).
// throughput: one sample per cycle while out_ready allows it; the three-stage
// pipeline moves as a whole and in_ready is high whenever the output register
// is empty or taken. when the receiver stalls, the output register holds its
// result and the pipeline and in_ready stop until out_ready returns.
// reset clears the window cells to zero, sets the sums to their bias, clears
// the held field to zero and sets mag_enable, zero offsets and an identity
// matrix. configuration writes (cfg_we/cfg_index/cfg_data) take effect at
// once and belong in idle periods.
module imu_average_and_mag_iron_correct_unit import imuavg_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sample_t                accel_x,
	input  sample_t                accel_y,
	input  sample_t                accel_z,
	input  sample_t                raw_mag_x,
	input  sample_t                raw_mag_y,
	input  sample_t                raw_mag_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sample_t                avg_x,
	output sample_t                avg_y,
	output sample_t                avg_z,
	output sample_t                field_x,
	output sample_t                field_y,
	output sample_t                field_z,
	output logic                   field_fresh,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic      adv;
	logic      take;
	logic      v1_q;
	logic      v2_q;
	logic      v3_q;
	pipe_ctl_t ctl;
	vec3_t     avg;
	vec3_t     field;

	// pipeline moves when the output register is free or being drained
	assign adv      = !v3_q || out_ready;
	assign take     = in_valid && adv;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else if (adv) begin
			v1_q <= take;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	assign ctl = '{adv: adv, take: take, v1: v1_q, v2: v2_q};

	// accelerometer window and mean
	imuavg_mean #(
		.WINDOW(WINDOW)
	) u_mean (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.accel ('{x: accel_x, y: accel_y, z: accel_z}),
		.avg   (avg)
	);

	// magnetometer correction
	imuavg_mag u_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.raw      ('{x: raw_mag_x, y: raw_mag_y, z: raw_mag_z}),
		.field    (field),
		.fresh    (field_fresh)
	);

	assign out_valid = v3_q;
	assign avg_x     = avg.x;
	assign avg_y     = avg.y;
	assign avg_z     = avg.z;
	assign field_x   = field.x;
	assign field_y   = field.y;
	assign field_z   = field.z;

	// an accepted transaction always occupies the first stage
	a_take_fill: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> v1_q)
		else $error("accepted transaction lost at stage 1");

	// a stalled pipeline keeps every stage in place
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v1_q, v2_q, v3_q}))
		else $error("pipeline moved during a stall");

endmodule
